/* sv/ucs_pkg.sv */
// Shared types and constants of the unit-fact clause simplifier.
`default_nettype none

package ucs_pkg;

    // Default sizes of the fact table and the clause buffer.
    localparam int N_VARS_DEF     = 65536;
    localparam int MAX_CLAUSE_DEF = 32;

    // Literal width, and the width used to range-check a variable number.
    localparam int LIT_W = 17;
    localparam int VAR_W = 26;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_FACT    = 2'd0,
        OP_CLAUSE  = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Kinds of result item.
    typedef enum logic [2:0] {
        KIND_KEPT  = 3'd0,
        KIND_END   = 3'd1,
        KIND_UNIT  = 3'd2,
        KIND_UNSAT = 3'd3,
        KIND_LONG  = 3'd4
    } t_kind;

    // One fact table entry.
    typedef struct packed {
        logic known;
        logic positive;
    } t_fact;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EMIT,
        S_DRAIN
    } t_state;

endpackage

`default_nettype wire

/* sv/ucs_ram.sv */
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module ucs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read ports; the read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/unit_fact_clause_simplifier.sv */
// Top level of the unit-fact clause simplifier.
//
// Input channel (i_valid, o_stall, i_op, i_literal): an item is taken at a
// clock edge with i_valid high and o_stall low. Op fact loads a unit fact
// into the fact table, op clause streams one clause literal (zero ends the
// clause), op restart clears the unsat flag and the clause in progress.
// Output channel (o_valid, i_stall, o_kind, o_out_literal, o_last): one
// result item per edge with o_valid high and i_stall low; o_last marks the
// final result caused by an input item.
// A fact or clause literal that is looked up reads the fact memory as the
// item is taken and acts on the entry read in S_LOOK; a contradicting fact
// then places its unsat result from S_EMIT. A restart, an ignored item, a
// fact outside the table, or an empty or satisfied clause end is done in
// S_IDLE. A clause end with k >= 2 kept literals goes to S_DRAIN, which
// places one result per literal drained from the clause buffer plus the
// terminator; other clause ends place their single result from S_EMIT.
// After reset the block sweeps the fact memory, one entry per cycle, with
// o_stall high until all N_VARS entries are cleared. A stalled receiver
// holds results in the output register; the block keeps working until a
// further result is due.
`default_nettype none

module unit_fact_clause_simplifier #(
    parameter int N_VARS     = ucs_pkg::N_VARS_DEF,
    parameter int MAX_CLAUSE = ucs_pkg::MAX_CLAUSE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_op,
    input  wire logic signed [ucs_pkg::LIT_W-1:0] i_literal,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [2:0]                           o_kind,
    output logic signed [ucs_pkg::LIT_W-1:0]     o_out_literal,
    output logic                                 o_last
);

    localparam int LW = ucs_pkg::LIT_W;
    localparam int VW = ucs_pkg::VAR_W;
    localparam int AW = $clog2(N_VARS);
    localparam int BW = $clog2(MAX_CLAUSE);
    localparam int CW = $clog2(MAX_CLAUSE + 1);
    localparam int FW = $bits(ucs_pkg::t_fact);
    localparam logic [VW-1:0] VARS_LIM = VW'(N_VARS);
    localparam logic [AW-1:0] CLR_LAST = AW'(N_VARS - 1);
    localparam logic [CW-1:0] KEPT_LIM = CW'(MAX_CLAUSE);

    // Control registers.
    ucs_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic [CW-1:0]   r_kept, n_kept;
    logic            r_seen, n_seen;
    logic            r_sat, n_sat;
    logic            r_ovf, n_ovf;
    logic            r_unsat, n_unsat;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_total, n_total;
    logic            r_out_valid, n_out_valid;

    // Payload registers.
    ucs_pkg::t_op    r_op, n_op;
    logic [LW-1:0]   r_lit, n_lit;
    logic            r_neg, n_neg;
    logic            r_in_range, n_in_range;
    logic [AW-1:0]   r_addr, n_addr;
    ucs_pkg::t_kind  r_pend, n_pend;
    ucs_pkg::t_kind  r_out_kind, n_out_kind;
    logic [LW-1:0]   r_out_lit, n_out_lit;
    logic            r_out_last, n_out_last;

    // Memory ports.
    logic            fact_wr_en, fact_rd_en;
    logic [AW-1:0]   fact_wr_addr;
    ucs_pkg::t_fact  fact_wr_data, fact_rd;
    logic [FW-1:0]   fact_rd_bits;
    logic            buf_wr_en, buf_rd_en;
    logic [BW-1:0]   buf_rd_addr;
    logic [LW-1:0]   buf_rd;

    // Decode of the incoming literal.
    logic            in_acc, out_free, in_neg, in_range, in_var_zero, in_lit_zero;
    logic            in_ignored;
    logic [LW-1:0]   in_bits, in_mag;
    logic [VW-1:0]   in_var;
    logic [CW-1:0]   idx_inc;
    ucs_pkg::t_op    in_op;

    assign in_op       = ucs_pkg::t_op'(i_op);
    assign in_bits     = i_literal;
    assign in_neg      = in_bits[LW-1];
    assign in_mag      = in_neg ? (LW'(0) - in_bits) : in_bits;
    assign in_var      = VW'(in_mag);
    assign in_range    = (in_var < VARS_LIM);
    assign in_var_zero = (in_mag == '0);
    assign in_lit_zero = (in_bits == '0);
    assign in_ignored  = r_unsat || (in_op == ucs_pkg::OP_NONE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign idx_inc     = r_idx + CW'(1);
    assign fact_rd     = ucs_pkg::t_fact'(fact_rd_bits);

    // Fact table: known and polarity bits per variable.
    ucs_ram #(
        .WIDTH (FW),
        .DEPTH (N_VARS)
    ) u_fact_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fact_wr_en),
        .i_wr_addr (fact_wr_addr),
        .i_wr_data (fact_wr_data),
        .i_rd_en   (fact_rd_en),
        .i_rd_addr (in_var[AW-1:0]),
        .o_rd_data (fact_rd_bits)
    );

    // Clause buffer of kept literals.
    ucs_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_CLAUSE)
    ) u_clause_ram (
        .i_clk     (i_clk),
        .i_wr_en   (buf_wr_en),
        .i_wr_addr (r_kept[BW-1:0]),
        .i_wr_data (r_lit),
        .i_rd_en   (buf_rd_en),
        .i_rd_addr (buf_rd_addr),
        .o_rd_data (buf_rd)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ucs_pkg::S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ucs_pkg::S_IDLE;
                end
            end
            ucs_pkg::S_IDLE: begin
                if (in_acc && !in_ignored) begin
                    if (in_op == ucs_pkg::OP_FACT) begin
                        if (!in_var_zero && in_range) begin
                            n_state = ucs_pkg::S_LOOK;
                        end
                    end else if (in_op == ucs_pkg::OP_CLAUSE) begin
                        if (in_lit_zero) begin
                            if (!r_sat && r_seen) begin
                                if (!r_ovf && (r_kept > CW'(1))) begin
                                    n_state = ucs_pkg::S_DRAIN;
                                end else begin
                                    n_state = ucs_pkg::S_EMIT;
                                end
                            end
                        end else if (!r_sat) begin
                            n_state = ucs_pkg::S_LOOK;
                        end
                    end
                end
            end
            ucs_pkg::S_LOOK: begin
                if ((r_op == ucs_pkg::OP_FACT) && fact_rd.known
                        && (fact_rd.positive == r_neg)) begin
                    n_state = ucs_pkg::S_EMIT;
                end else begin
                    n_state = ucs_pkg::S_IDLE;
                end
            end
            ucs_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = ucs_pkg::S_IDLE;
                end
            end
            ucs_pkg::S_DRAIN: begin
                if (out_free && (r_idx == r_total)) begin
                    n_state = ucs_pkg::S_IDLE;
                end
            end
            default: n_state = ucs_pkg::S_CLEAR;
        endcase
    end

    // Datapath, memory accesses and result loading per state.
    always_comb begin
        n_clr_addr   = r_clr_addr;
        n_kept       = r_kept;
        n_seen       = r_seen;
        n_sat        = r_sat;
        n_ovf        = r_ovf;
        n_unsat      = r_unsat;
        n_idx        = r_idx;
        n_total      = r_total;
        n_op         = r_op;
        n_lit        = r_lit;
        n_neg        = r_neg;
        n_in_range   = r_in_range;
        n_addr       = r_addr;
        n_pend       = r_pend;
        n_out_kind   = r_out_kind;
        n_out_lit    = r_out_lit;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && i_stall;
        fact_wr_en   = 1'b0;
        fact_wr_addr = r_addr;
        fact_wr_data = '{known: 1'b1, positive: !r_neg};
        fact_rd_en   = 1'b0;
        buf_wr_en    = 1'b0;
        buf_rd_en    = 1'b0;
        buf_rd_addr  = '0;
        case (r_state)
            ucs_pkg::S_CLEAR: begin
                fact_wr_en   = 1'b1;
                fact_wr_addr = r_clr_addr;
                fact_wr_data = '{known: 1'b0, positive: 1'b0};
                n_clr_addr   = r_clr_addr + AW'(1);
            end
            ucs_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op       = in_op;
                    n_lit      = in_bits;
                    n_neg      = in_neg;
                    n_in_range = in_range;
                    n_addr     = in_var[AW-1:0];
                    if (in_op == ucs_pkg::OP_RESTART) begin
                        n_unsat = 1'b0;
                        n_kept  = '0;
                        n_seen  = 1'b0;
                        n_sat   = 1'b0;
                        n_ovf   = 1'b0;
                    end else if (!in_ignored && (in_op == ucs_pkg::OP_FACT)) begin
                        fact_rd_en = 1'b1;
                    end else if (!in_ignored && (in_op == ucs_pkg::OP_CLAUSE)) begin
                        if (in_lit_zero) begin
                            // Clause end: decide the outcome, then clear the clause.
                            buf_rd_en = 1'b1;
                            n_idx     = '0;
                            n_total   = r_kept;
                            if (r_ovf) begin
                                n_pend = ucs_pkg::KIND_LONG;
                            end else if (r_kept == '0) begin
                                n_pend = ucs_pkg::KIND_UNSAT;
                                if (!r_sat && r_seen) begin
                                    n_unsat = 1'b1;
                                end
                            end else begin
                                n_pend = ucs_pkg::KIND_UNIT;
                            end
                            n_kept = '0;
                            n_seen = 1'b0;
                            n_sat  = 1'b0;
                            n_ovf  = 1'b0;
                        end else if (!r_sat) begin
                            fact_rd_en = 1'b1;
                        end
                    end
                end
            end
            ucs_pkg::S_LOOK: begin
                if (r_op == ucs_pkg::OP_FACT) begin
                    // Fact load: record a new fact or flag a contradiction.
                    if (!fact_rd.known) begin
                        fact_wr_en = 1'b1;
                    end else if (fact_rd.positive == r_neg) begin
                        n_unsat = 1'b1;
                        n_pend  = ucs_pkg::KIND_UNSAT;
                    end
                end else begin
                    // Clause literal: satisfied, falsified, kept or overflowing the buffer.
                    n_seen = 1'b1;
                    if (r_in_range && fact_rd.known) begin
                        if (fact_rd.positive != r_neg) begin
                            n_sat  = 1'b1;
                            n_kept = '0;
                            n_ovf  = 1'b0;
                        end
                    end else if (r_kept < KEPT_LIM) begin
                        buf_wr_en = 1'b1;
                        n_kept    = r_kept + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ucs_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_pend;
                    n_out_lit   = (r_pend == ucs_pkg::KIND_UNIT) ? buf_rd : '0;
                    n_out_last  = 1'b1;
                end
            end
            ucs_pkg::S_DRAIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_idx == r_total) begin
                        n_out_kind = ucs_pkg::KIND_END;
                        n_out_lit  = '0;
                        n_out_last = 1'b1;
                    end else begin
                        n_out_kind  = ucs_pkg::KIND_KEPT;
                        n_out_lit   = buf_rd;
                        n_out_last  = 1'b0;
                        n_idx       = idx_inc;
                        buf_rd_en   = 1'b1;
                        buf_rd_addr = idx_inc[BW-1:0];
                    end
                end
            end
            default: begin
                n_clr_addr = '0;
            end
        endcase
    end

    // Control registers with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ucs_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_kept      <= '0;
            r_seen      <= 1'b0;
            r_sat       <= 1'b0;
            r_ovf       <= 1'b0;
            r_unsat     <= 1'b0;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_kept      <= n_kept;
            r_seen      <= n_seen;
            r_sat       <= n_sat;
            r_ovf       <= n_ovf;
            r_unsat     <= n_unsat;
            r_idx       <= n_idx;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_lit      <= n_lit;
        r_neg      <= n_neg;
        r_in_range <= n_in_range;
        r_addr     <= n_addr;
        r_pend     <= n_pend;
        r_out_kind <= n_out_kind;
        r_out_lit  <= n_out_lit;
        r_out_last <= n_out_last;
    end

    // Ports.
    assign o_stall       = (r_state != ucs_pkg::S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_out_literal = r_out_lit;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

/* sv/ucs_checker.sv */
// Port-level checker of the unit-fact clause simplifier and its bind.
`default_nettype none

module ucs_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_valid,
    input wire logic                             o_stall,
    input wire logic [1:0]                       i_op,
    input wire logic signed [ucs_pkg::LIT_W-1:0] i_literal,
    input wire logic                             o_valid,
    input wire logic                             i_stall,
    input wire logic [2:0]                       o_kind,
    input wire logic signed [ucs_pkg::LIT_W-1:0] o_out_literal,
    input wire logic                             o_last
);

    // The fact memory sweep keeps the input stalled straight after reset.
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled after reset");

    // Terminators, unsat and overflow results carry a zero literal and end the item.
    a_no_literal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == 3'(ucs_pkg::KIND_END) || o_kind == 3'(ucs_pkg::KIND_UNSAT)
            || o_kind == 3'(ucs_pkg::KIND_LONG))
        |-> (o_out_literal == '0) && o_last)
        else $error("non-literal result with literal or without last");

    // Kept literals and new unit facts are never the zero literal.
    a_literal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == 3'(ucs_pkg::KIND_KEPT) || o_kind == 3'(ucs_pkg::KIND_UNIT))
        |-> (o_out_literal != '0))
        else $error("zero literal emitted");

    // A kept literal is never the final result of an item.
    a_kept_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == 3'(ucs_pkg::KIND_KEPT)) |-> !o_last)
        else $error("kept literal marked last");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_out_literal)
            && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind unit_fact_clause_simplifier ucs_checker u_ucs_checker (.*);

`default_nettype wire

/* test/tb_unit_fact_clause_simplifier.sv */
// Self-checking testbench for the unit-fact clause simplifier, with its own prediction of results.
`timescale 1ns / 100ps

module tb_unit_fact_clause_simplifier;

    // Run shape: items sent, idle rate, receiver hold-off and timeouts.
    localparam int ITEM_TARGET  = 480;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 40;
    localparam int STUCK_LIMIT  = 4 * ucs_pkg::N_VARS_DEF;
    localparam int FACT_AW      = $clog2(ucs_pkg::N_VARS_DEF);

    typedef logic signed [ucs_pkg::LIT_W-1:0] t_lit;

    typedef struct packed {
        ucs_pkg::t_op op;
        t_lit         lit;
    } t_item;

    typedef struct packed {
        ucs_pkg::t_kind kind;
        t_lit           lit;
        logic           last;
    } t_result;

    // Block ports; the inputs are driven to known values from time zero.
    logic         i_clk     = 1'b0;
    logic         i_rst_n   = 1'b0;
    logic         i_valid   = 1'b0;
    ucs_pkg::t_op i_op      = ucs_pkg::OP_NONE;
    t_lit         i_literal = '0;
    logic         i_stall   = 1'b0;
    logic         o_stall;
    logic         o_valid;
    logic [2:0]   o_kind;
    t_lit         o_out_literal;
    logic         o_last;

    // Items waiting to be offered, and results the block still owes.
    t_item   stim_items[$];
    t_result due_results[$];

    // Fact literals handed out so far, used to build hits and misses in clauses.
    t_lit fact_lits[$];

    // Shadow copy of the fact table and the clause in progress.
    bit   facts_known [0:ucs_pkg::N_VARS_DEF-1];
    bit   facts_pos   [0:ucs_pkg::N_VARS_DEF-1];
    t_lit kept_buf    [0:ucs_pkg::MAX_CLAUSE_DEF-1];
    int   kept_n      = 0;
    bit   clause_seen = 1'b0;
    bit   clause_sat  = 1'b0;
    bit   clause_long = 1'b0;
    bit   unsat_set   = 1'b0;

    // Bookkeeping.
    int n_queued    = 0;
    int n_in        = 0;
    int n_effective = 0;
    int n_out       = 0;
    int n_err       = 0;
    int n_kind[0:4] = '{default: 0};
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int stuck       = 0;

    // A stretch of the run where neither side idles.
    wire quiet = (n_in >= 200) && (n_in < 330);

    unit_fact_clause_simplifier dut (.*);

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Append one owed result at the tail of the queue.
    task automatic owe_result(input ucs_pkg::t_kind kind, input t_lit lit, input logic last);
        t_result r;
        r = '{kind, lit, last};
        due_results.insert(due_results.size(), r);
    endtask

    // Work out the results that one accepted item must cause.
    task automatic simplify_item(input ucs_pkg::t_op op, input t_lit lit);
        logic [ucs_pkg::LIT_W-1:0] vnum;
        logic neg;
        int i;
        neg  = lit[ucs_pkg::LIT_W-1];
        vnum = neg ? -lit : lit;
        if (op == ucs_pkg::OP_RESTART) begin
            unsat_set   = 1'b0;
            kept_n      = 0;
            clause_seen = 1'b0;
            clause_sat  = 1'b0;
            clause_long = 1'b0;
            n_effective++;
            return;
        end
        if (op == ucs_pkg::OP_NONE || unsat_set)
            return;
        n_effective++;
        if (op == ucs_pkg::OP_FACT) begin
            // Variable zero and the one pattern beyond the table are dropped.
            if (vnum == 0 || vnum[ucs_pkg::LIT_W-1])
                return;
            if (facts_known[vnum[FACT_AW-1:0]]) begin
                if (facts_pos[vnum[FACT_AW-1:0]] == neg) begin
                    unsat_set = 1'b1;
                    owe_result(ucs_pkg::KIND_UNSAT, '0, 1'b1);
                end
            end else begin
                facts_known[vnum[FACT_AW-1:0]] = 1'b1;
                facts_pos[vnum[FACT_AW-1:0]]   = !neg;
            end
            return;
        end
        // Clause terminator: decide what the clause becomes.
        if (lit == 0) begin
            if (!clause_sat && clause_seen) begin
                if (clause_long) begin
                    owe_result(ucs_pkg::KIND_LONG, '0, 1'b1);
                end else if (kept_n == 0) begin
                    unsat_set = 1'b1;
                    owe_result(ucs_pkg::KIND_UNSAT, '0, 1'b1);
                end else if (kept_n == 1) begin
                    owe_result(ucs_pkg::KIND_UNIT, kept_buf[0], 1'b1);
                end else begin
                    for (i = 0; i < kept_n; i++)
                        owe_result(ucs_pkg::KIND_KEPT, kept_buf[i], 1'b0);
                    owe_result(ucs_pkg::KIND_END, '0, 1'b1);
                end
            end
            kept_n      = 0;
            clause_seen = 1'b0;
            clause_sat  = 1'b0;
            clause_long = 1'b0;
            return;
        end
        if (clause_sat)
            return;
        clause_seen = 1'b1;
        // A known variable either satisfies the clause or drops the literal.
        if (!vnum[ucs_pkg::LIT_W-1] && facts_known[vnum[FACT_AW-1:0]]) begin
            if (facts_pos[vnum[FACT_AW-1:0]] != neg) begin
                clause_sat  = 1'b1;
                kept_n      = 0;
                clause_long = 1'b0;
            end
        end else if (kept_n < ucs_pkg::MAX_CLAUSE_DEF) begin
            kept_buf[kept_n] = lit;
            kept_n++;
        end else begin
            clause_long = 1'b1;
        end
    endtask

    // Random literal of a nonzero variable in the table, now and then the pattern beyond the table.
    function automatic t_lit fresh_lit();
        logic [ucs_pkg::LIT_W-1:0] mag;
        if ($urandom_range(49) == 0)
            return t_lit'(17'h10000);
        mag = $urandom_range(65535, 1);
        return $urandom_range(1) ? -t_lit'(mag) : t_lit'(mag);
    endfunction

    // Clause literal: opposite of a fact, equal to a fact, or a random literal.
    function automatic t_lit clause_lit(input int pct_false, input int pct_true);
        int r;
        t_lit f;
        r = $urandom_range(99);
        if (fact_lits.size() == 0 || r >= pct_false + pct_true)
            return fresh_lit();
        f = fact_lits[$urandom_range(fact_lits.size() - 1)];
        return (r < pct_false) ? -f : f;
    endfunction

    task automatic add_item(input ucs_pkg::t_op op, input t_lit lit);
        t_item it;
        it = '{op, lit};
        stim_items.insert(stim_items.size(), it);
        n_queued++;
    endtask

    // Sender: offers queued items, holds a stalled item, idles at random.
    always @(posedge i_clk) begin : drive_items
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                simplify_item(i_op, i_literal);
                n_in++;
            end
            if (!i_valid || !o_stall) begin
                if (stim_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = stim_items.pop_front();
                    i_valid   <= 1'b1;
                    i_op      <= nxt.op;
                    i_literal <= nxt.lit;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest one owed, stalls at random.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_out++;
                if (o_kind <= ucs_pkg::KIND_LONG)
                    n_kind[o_kind]++;
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d, out_literal %0d, last %0b",
                           o_kind, o_out_literal, o_last);
                    n_err++;
                end else begin
                    want = due_results.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                        n_err++;
                    end
                    if (o_out_literal !== want.lit) begin
                        $error("out_literal: expected %0d, actual %0d",
                               $signed(want.lit), o_out_literal);
                        n_err++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, o_last);
                        n_err++;
                    end
                end
            end
            // One long hold-off while a result waits, so that the block backs up.
            if (hold_left != 0) begin
                hold_left--;
            end else if (!hold_done && n_in >= 120 && o_valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            i_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck >= STUCK_LIMIT) begin
                $display("timeout after %0d idle cycles", stuck);
                $display("tb_unit_fact_clause_simplifier: done, errors");
                $finish;
            end
        end
    end

    // Directed items, reset, then random traffic until enough items are queued; then drain and report.
    initial begin : stimulus
        int r;
        int n;
        int s;
        bit contra;
        bit paused;
        t_lit f;
        paused = 1'b0;

        // Ignored op, facts including zero and out of table, and a repeated fact.
        add_item(ucs_pkg::OP_NONE, t_lit'(17'h1FFFF));
        add_item(ucs_pkg::OP_FACT, 5);
        add_item(ucs_pkg::OP_FACT, -7);
        add_item(ucs_pkg::OP_FACT, 65535);
        add_item(ucs_pkg::OP_FACT, 0);
        add_item(ucs_pkg::OP_FACT, t_lit'(17'h10000));
        add_item(ucs_pkg::OP_FACT, 5);
        // Clause with a falsified literal removed, two kept.
        add_item(ucs_pkg::OP_CLAUSE, 3);
        add_item(ucs_pkg::OP_CLAUSE, -5);
        add_item(ucs_pkg::OP_CLAUSE, 65534);
        add_item(ucs_pkg::OP_CLAUSE, 0);
        // Out-of-table literal kept alone: a new unit fact.
        add_item(ucs_pkg::OP_CLAUSE, t_lit'(17'h10000));
        add_item(ucs_pkg::OP_CLAUSE, 7);
        add_item(ucs_pkg::OP_CLAUSE, 0);
        // Satisfied clause, then an empty clause.
        add_item(ucs_pkg::OP_CLAUSE, 5);
        add_item(ucs_pkg::OP_CLAUSE, 11);
        add_item(ucs_pkg::OP_CLAUSE, 0);
        add_item(ucs_pkg::OP_CLAUSE, 0);
        // Every literal falsified, then items ignored while unsat is sticky.
        add_item(ucs_pkg::OP_CLAUSE, -65535);
        add_item(ucs_pkg::OP_CLAUSE, 0);
        add_item(ucs_pkg::OP_FACT, 100);
        add_item(ucs_pkg::OP_CLAUSE, 1);
        add_item(ucs_pkg::OP_RESTART, 0);
        // Contradicting fact load.
        add_item(ucs_pkg::OP_FACT, -5);
        add_item(ucs_pkg::OP_RESTART, 0);
        fact_lits = '{5, -7, 65535};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_queued < ITEM_TARGET) begin
            while (stim_items.size() >= 8)
                @(posedge i_clk);
            // Once mid-run the sender waits for every owed result.
            if (!paused && n_queued >= 300) begin
                paused = 1'b1;
                while (stim_items.size() != 0 || i_valid)
                    @(posedge i_clk);
                while (due_results.size() != 0)
                    @(posedge i_clk);
            end
            r = $urandom_range(99);
            if (r < 8) begin
                add_item(ucs_pkg::OP_RESTART, t_lit'($urandom));
            end else if (r < 24) begin
                // A few fact loads, sometimes contradicting or ignored.
                contra = 1'b0;
                n = $urandom_range(4, 1);
                repeat (n) begin
                    s = $urandom_range(99);
                    if (s < 8) begin
                        add_item(ucs_pkg::OP_FACT,
                                 -fact_lits[$urandom_range(fact_lits.size() - 1)]);
                        contra = 1'b1;
                    end else if (s < 14) begin
                        add_item(ucs_pkg::OP_FACT,
                                 $urandom_range(1) ? t_lit'(0) : t_lit'(17'h10000));
                    end else begin
                        f = fresh_lit();
                        add_item(ucs_pkg::OP_FACT, f);
                        if (f != t_lit'(17'h10000))
                            fact_lits.insert(fact_lits.size(), f);
                    end
                end
                if (contra && $urandom_range(99) < 70)
                    add_item(ucs_pkg::OP_RESTART, 0);
            end else if (r < 30) begin
                // Noise: unknown ops, random clause literals and bare terminators.
                n = $urandom_range(3, 1);
                repeat (n)
                    add_item($urandom_range(1) ? ucs_pkg::OP_NONE : ucs_pkg::OP_CLAUSE,
                             $urandom_range(1) ? t_lit'($urandom) : t_lit'(0));
            end else if (r < 36) begin
                // Clause broken off by a restart.
                n = $urandom_range(5, 1);
                repeat (n)
                    add_item(ucs_pkg::OP_CLAUSE, clause_lit(25, 8));
                add_item(ucs_pkg::OP_RESTART, 0);
            end else if (r < 44) begin
                // Clause near or past the buffer size.
                n = $urandom_range(34, 29);
                repeat (n)
                    add_item(ucs_pkg::OP_CLAUSE, clause_lit(4, 1));
                add_item(ucs_pkg::OP_CLAUSE, 0);
            end else if (r < 52) begin
                // Every literal falsified.
                n = $urandom_range(3, 1);
                repeat (n)
                    add_item(ucs_pkg::OP_CLAUSE, clause_lit(100, 0));
                add_item(ucs_pkg::OP_CLAUSE, 0);
                if ($urandom_range(99) < 70)
                    add_item(ucs_pkg::OP_RESTART, 0);
            end else begin
                // Ordinary short clause.
                n = $urandom_range(6, 0);
                repeat (n)
                    add_item(ucs_pkg::OP_CLAUSE, clause_lit(25, 8));
                add_item(ucs_pkg::OP_CLAUSE, 0);
                if ($urandom_range(99) < 15)
                    add_item(ucs_pkg::OP_RESTART, 0);
            end
        end

        // Let everything drain, then allow for stray results.
        while (stim_items.size() != 0 || i_valid)
            @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items (%0d acted on) and %0d results checked.",
                 n_in, n_effective, n_out);
        $display("Results: %0d kept, %0d clause ends, %0d units, %0d unsat, %0d too long.",
                 n_kind[0], n_kind[1], n_kind[2], n_kind[3], n_kind[4]);
        if (n_err == 0) begin
            $display("tb_unit_fact_clause_simplifier: done, clean");
        end else begin
            $display("tb_unit_fact_clause_simplifier: done, errors");
        end
        $finish;
    end

endmodule
